### sv/quaternion_nlerp_assert.svh
// ---------------------------------------------------------------------------
// quaternion_nlerp assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_NLERP_ASSERT_SVH
`define QUATERNION_NLERP_ASSERT_SVH

// Same-cycle implication.
`define QNLERP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QNLERP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define QNLERP_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

### sv/qnlerp_pkg.sv
// ---------------------------------------------------------------------------
// qnlerp_pkg
// Widths, constants, transaction types and helpers for the quaternion nlerp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qnlerp_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int COMP_W      = 16;
  localparam int BLEND_W     = 16;
  localparam int BLEND_SHIFT = 15;
  localparam int BLEND_ONE   = 1 << BLEND_SHIFT;
  localparam int BLEND_HALF  = 1 << (BLEND_SHIFT - 1);
  localparam int NUM_LANES   = 4;
  localparam int COMP_MAX    = (1 << (COMP_W - 1)) - 1;

  localparam int DIFF_W   = COMP_W + 1;
  localparam int PROD_W   = DIFF_W + BLEND_W + 1;
  localparam int SQ_W     = 2 * COMP_W - 1;
  localparam int LEN_W    = SQ_W + 2;
  localparam int SAT_IN_W = (FRAC_BITS + 2 > COMP_W + 4) ? FRAC_BITS + 2 : COMP_W + 4;

  // Root digit recurrence: one stage per result bit.
  localparam int NUM_STEPS = FRAC_BITS + 1;
  localparam int N_W       = FRAC_BITS + 1;
  localparam int P_W       = LEN_W + FRAC_BITS + 2;
  localparam int R_W       = LEN_W + 2 * FRAC_BITS + 5;

  // Accept to strobe: 3 lane stages, merge/align, init, root steps, output.
  localparam int LATENCY = NUM_STEPS + 6;

  localparam longint unsigned THRESH = (64'd1 << (2 * FRAC_BITS)) / 64'd1000;

  typedef logic signed [COMP_W-1:0] comp_t;

  localparam comp_t ONE_Q = (FRAC_BITS >= COMP_W - 1) ? comp_t'(COMP_MAX)
                                                      : comp_t'(1 << FRAC_BITS);

  typedef struct packed {
    comp_t              u_x;
    comp_t              u_y;
    comp_t              u_z;
    comp_t              u_w;
    comp_t              v_x;
    comp_t              v_y;
    comp_t              v_z;
    comp_t              v_w;
    logic [BLEND_W-1:0] blend;
  } request_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    comp_t out_w;
    logic  degenerate;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0] len2;
    logic             degenerate;
  } len_info_t;

  function automatic comp_t sat_comp(input logic signed [SAT_IN_W-1:0] x);
    logic signed [SAT_IN_W-1:0] hi_lim;
    logic signed [SAT_IN_W-1:0] lo_lim;
    comp_t                      res;
    hi_lim = SAT_IN_W'(COMP_MAX);
    lo_lim = SAT_IN_W'(-COMP_MAX - 1);
    if (x > hi_lim) begin
      res = comp_t'(COMP_MAX);
    end else if (x < lo_lim) begin
      res = comp_t'(-COMP_MAX - 1);
    end else begin
      res = x[COMP_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/qnlerp_lerp_lane.sv
// ---------------------------------------------------------------------------
// qnlerp_lerp_lane
// One component: blend u toward v, saturate, and square the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qnlerp_lerp_lane (
  input  logic                              clk,
  input  qnlerp_pkg::comp_t                 u,
  input  qnlerp_pkg::comp_t                 v,
  input  logic [qnlerp_pkg::BLEND_W-1:0]    blend,
  output logic [qnlerp_pkg::SQ_W-1:0]       qsq,
  output logic                              neg
);

  logic [qnlerp_pkg::BLEND_W-1:0]                               t_clamp;
  logic signed [qnlerp_pkg::DIFF_W-1:0]                         diff;
  logic signed [qnlerp_pkg::PROD_W-1:0]                         prod;
  qnlerp_pkg::comp_t                                            u_d;
  logic signed [qnlerp_pkg::PROD_W-1:0]                         prod_rnd;
  logic signed [qnlerp_pkg::PROD_W-qnlerp_pkg::BLEND_SHIFT-1:0] step;
  logic signed [qnlerp_pkg::SAT_IN_W-1:0]                       sum;
  qnlerp_pkg::comp_t                                            q;
  logic signed [2*qnlerp_pkg::COMP_W-1:0]                       sq_full;

  always_comb begin
    // clamp t to one
    t_clamp  = (blend > qnlerp_pkg::BLEND_W'(qnlerp_pkg::BLEND_ONE)) ?
               qnlerp_pkg::BLEND_W'(qnlerp_pkg::BLEND_ONE) : blend;
    diff     = qnlerp_pkg::DIFF_W'(v) - qnlerp_pkg::DIFF_W'(u);
    // round half up, then floor shift
    prod_rnd = prod + qnlerp_pkg::PROD_W'(qnlerp_pkg::BLEND_HALF);
    step     = prod_rnd[qnlerp_pkg::PROD_W-1:qnlerp_pkg::BLEND_SHIFT];
    sum      = qnlerp_pkg::SAT_IN_W'(u_d) + qnlerp_pkg::SAT_IN_W'(step);
    sq_full  = q * q;
  end

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, t_clamp}) * diff;
    u_d  <= u;
    q    <= qnlerp_pkg::sat_comp(sum);
    qsq  <= sq_full[qnlerp_pkg::SQ_W-1:0];
    neg  <= q[qnlerp_pkg::COMP_W-1];
  end

endmodule

`default_nettype wire

### sv/qnlerp_len_merge.sv
// ---------------------------------------------------------------------------
// qnlerp_len_merge
// Sum the lane squares into the squared length and test it against the floor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qnlerp_len_merge (
  input  logic                                                  clk,
  input  logic [qnlerp_pkg::NUM_LANES-1:0][qnlerp_pkg::SQ_W-1:0] qsq,
  output qnlerp_pkg::len_info_t                                 info
);

  logic [qnlerp_pkg::LEN_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < qnlerp_pkg::NUM_LANES; i++) begin
      sum = sum + qnlerp_pkg::LEN_W'(qsq[i]);
    end
  end

  always_ff @(posedge clk) begin
    info.len2       <= sum;
    info.degenerate <= !(64'(sum) > qnlerp_pkg::THRESH);
  end

endmodule

`default_nettype wire

### sv/qnlerp_norm_lane.sv
// ---------------------------------------------------------------------------
// qnlerp_norm_lane
// Pipelined digit recurrence for round(|q| * 2^F / sqrt(L)), one bit a stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qnlerp_norm_lane (
  input  logic                           clk,
  input  logic [qnlerp_pkg::SQ_W-1:0]    qsq,
  input  logic                           neg,
  input  logic [qnlerp_pkg::LEN_W-1:0]   len2,
  output logic [qnlerp_pkg::N_W-1:0]     mag,
  output logic                           mag_neg
);

  // rem = q^2 * 2^(2F+2) - (2n-1)^2 * L, prd = (2n-1) * L
  logic                                signed_unused;
  logic [qnlerp_pkg::SQ_W-1:0]         qsq_d;
  logic                                neg_d;
  logic signed [qnlerp_pkg::R_W-1:0]   rem   [qnlerp_pkg::NUM_STEPS+1];
  logic signed [qnlerp_pkg::P_W-1:0]   prd   [qnlerp_pkg::NUM_STEPS+1];
  logic [qnlerp_pkg::N_W-1:0]          root  [qnlerp_pkg::NUM_STEPS+1];
  logic [qnlerp_pkg::LEN_W-1:0]        len_s [qnlerp_pkg::NUM_STEPS+1];
  logic                                sgn   [qnlerp_pkg::NUM_STEPS+1];

  assign signed_unused = 1'b0;

  // align the lane square with the merged length, then seed n = 0
  always_ff @(posedge clk) begin
    qsq_d    <= qsq;
    neg_d    <= neg | signed_unused;
    rem[0]   <= (qnlerp_pkg::R_W'(qsq_d) << (2 * qnlerp_pkg::FRAC_BITS + 2))
                - qnlerp_pkg::R_W'(len2);
    prd[0]   <= qnlerp_pkg::P_W'(0) - qnlerp_pkg::P_W'(len2);
    root[0]  <= '0;
    len_s[0] <= len2;
    sgn[0]   <= neg_d;
  end

  for (genvar s = 0; s < qnlerp_pkg::NUM_STEPS; s++) begin : g_step
    localparam int K = qnlerp_pkg::FRAC_BITS - s;

    logic signed [qnlerp_pkg::R_W-1:0] p_sh;
    logic signed [qnlerp_pkg::R_W-1:0] l_sh;
    logic signed [qnlerp_pkg::R_W-1:0] trial;
    logic signed [qnlerp_pkg::P_W-1:0] p_add;

    // try n + 2^K: odd term grows by 2^(K+1)
    assign p_sh  = qnlerp_pkg::R_W'(prd[s]) <<< (K + 2);
    assign l_sh  = qnlerp_pkg::R_W'(len_s[s]) << (2 * K + 2);
    assign trial = rem[s] - p_sh - l_sh;
    assign p_add = qnlerp_pkg::P_W'(len_s[s]) << (K + 1);

    always_ff @(posedge clk) begin
      if (!trial[qnlerp_pkg::R_W-1]) begin
        rem[s+1]  <= trial;
        prd[s+1]  <= prd[s] + p_add;
        root[s+1] <= root[s] | (qnlerp_pkg::N_W'(1) << K);
      end else begin
        rem[s+1]  <= rem[s];
        prd[s+1]  <= prd[s];
        root[s+1] <= root[s];
      end
      len_s[s+1] <= len_s[s];
      sgn[s+1]   <= sgn[s];
    end
  end

  assign mag     = root[qnlerp_pkg::NUM_STEPS];
  assign mag_neg = sgn[qnlerp_pkg::NUM_STEPS];

endmodule

`default_nettype wire

### sv/quaternion_nlerp.sv
// ---------------------------------------------------------------------------
// quaternion_nlerp
// Normalized linear interpolation of two Q1.14 quaternions, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive request (u, v, blend) and raise start. A transaction
//   is taken at every rising edge with start high and busy low. busy is low
//   in normal operation, so a new transaction can enter every cycle.
//   Output channel: result is valid for exactly one cycle while done is high.
//   The receiver cannot stall; it must take each result in that cycle.
// Ordering: results appear in acceptance order.
// Throughput: one transaction per cycle while busy is low. The root
//   recurrence is pipelined, one result bit per pipeline stage in each of four lanes.
// Reset: rst is synchronous, active high. It drops every transaction in
//   flight and holds busy high for the cycle after rst is released.
// Structure: four lerp lanes (blend, saturate, square), a merge stage that
//   sums the squared length and flags the degenerate case, four normalize
//   lanes, and an output register that applies sign, saturation and the
//   identity substitution.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_nlerp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  qnlerp_pkg::request_t  request,
  output logic                  done,
  output qnlerp_pkg::result_t   result
);

`include "quaternion_nlerp_assert.svh"

  qnlerp_pkg::comp_t [qnlerp_pkg::NUM_LANES-1:0]                    u_lane;
  qnlerp_pkg::comp_t [qnlerp_pkg::NUM_LANES-1:0]                    v_lane;
  logic [qnlerp_pkg::NUM_LANES-1:0][qnlerp_pkg::SQ_W-1:0]           qsq;
  logic [qnlerp_pkg::NUM_LANES-1:0]                                 qneg;
  qnlerp_pkg::len_info_t                                            info;
  logic [qnlerp_pkg::NUM_LANES-1:0][qnlerp_pkg::N_W-1:0]            mag;
  logic [qnlerp_pkg::NUM_LANES-1:0]                                 mag_neg;
  logic signed [qnlerp_pkg::SAT_IN_W-1:0]                           mag_ext [qnlerp_pkg::NUM_LANES];
  logic signed [qnlerp_pkg::SAT_IN_W-1:0]                           sval    [qnlerp_pkg::NUM_LANES];
  qnlerp_pkg::comp_t [qnlerp_pkg::NUM_LANES-1:0]                    comp_val;

  // valid of each stage before the output register; done marks the output register
  logic [qnlerp_pkg::LATENCY-2:0]                                   vld;
  // degenerate flag, carried alongside the normalize lanes
  logic [qnlerp_pkg::NUM_STEPS:0]                                   deg_d;
  qnlerp_pkg::result_t                                              result_next;
  logic                                                             accept;

  assign accept = start && !busy;

  // Lane order x, y, z, w.
  assign u_lane = {request.u_w, request.u_z, request.u_y, request.u_x};
  assign v_lane = {request.v_w, request.v_z, request.v_y, request.v_x};

  for (genvar i = 0; i < qnlerp_pkg::NUM_LANES; i++) begin : g_lane
    qnlerp_lerp_lane u_lerp (
      .clk   (clk),
      .u     (u_lane[i]),
      .v     (v_lane[i]),
      .blend (request.blend),
      .qsq   (qsq[i]),
      .neg   (qneg[i])
    );

    qnlerp_norm_lane u_norm (
      .clk     (clk),
      .qsq     (qsq[i]),
      .neg     (qneg[i]),
      .len2    (info.len2),
      .mag     (mag[i]),
      .mag_neg (mag_neg[i])
    );
  end

  // Sum the four squares and flag a length at or below the floor.
  qnlerp_len_merge u_merge (
    .clk  (clk),
    .qsq  (qsq),
    .info (info)
  );

  // Reapply sign and saturate; substitute identity for a degenerate length.
  always_comb begin
    for (int i = 0; i < qnlerp_pkg::NUM_LANES; i++) begin
      mag_ext[i]  = qnlerp_pkg::SAT_IN_W'(mag[i]);
      sval[i]     = mag_neg[i] ? -mag_ext[i] : mag_ext[i];
      comp_val[i] = qnlerp_pkg::sat_comp(sval[i]);
    end
    if (deg_d[qnlerp_pkg::NUM_STEPS]) begin
      result_next.out_x      = '0;
      result_next.out_y      = '0;
      result_next.out_z      = '0;
      result_next.out_w      = qnlerp_pkg::ONE_Q;
      result_next.degenerate = 1'b1;
    end else begin
      result_next.out_x      = comp_val[0];
      result_next.out_y      = comp_val[1];
      result_next.out_z      = comp_val[2];
      result_next.out_w      = comp_val[3];
      result_next.degenerate = 1'b0;
    end
  end

  // Payload path: advance every cycle, no reset needed.
  always_ff @(posedge clk) begin
    deg_d  <= {deg_d[qnlerp_pkg::NUM_STEPS-1:0], info.degenerate};
    result <= result_next;
  end

  // Control path: drop in-flight transactions on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
      busy <= 1'b1;
    end else begin
      vld  <= {vld[qnlerp_pkg::LATENCY-3:0], accept};
      done <= vld[qnlerp_pkg::LATENCY-2];
      busy <= 1'b0;
    end
  end

  // Every accepted transaction produces a result strobe.
  `QNLERP_ASSERT_DELAY(a_accept_done, accept, qnlerp_pkg::LATENCY, done, "missing result strobe")

  // No strobe without a matching transaction.
  `QNLERP_ASSERT_IMPL(a_done_src, done, $past(accept, qnlerp_pkg::LATENCY), "result without transaction")

  // Identity must accompany the degenerate flag.
  `QNLERP_ASSERT_IMPL(a_ident, done && result.degenerate, (result.out_x == '0) && (result.out_y == '0) && (result.out_z == '0) && (result.out_w == qnlerp_pkg::ONE_Q), "degenerate result is not identity")

  // The normalized x component stays within unit magnitude.
  `QNLERP_ASSERT_IMPL(a_unit_x, done && !result.degenerate, (result.out_x <= qnlerp_pkg::ONE_Q) && (result.out_x >= -qnlerp_pkg::ONE_Q), "x exceeds unit magnitude")

  // busy drops after reset and stays low while rst stays low.
  `QNLERP_ASSERT_NEXT(a_busy_low, !rst, !busy, "busy held outside reset")

endmodule

`default_nettype wire
